[rtl/hbk_pkg.sv]
// Shared types, constants and helper functions for the boot keyboard report parser.
// No dependencies; imported by every module of the block.
package hbk_pkg;

    localparam int KEY_SLOTS   = 6;
    localparam int REPORT_KEYS = 6;
    localparam int USAGE_RANGE = 128;
    localparam int USAGE_W     = $clog2(USAGE_RANGE);
    localparam int SLOT_W      = (KEY_SLOTS > 1) ? $clog2(KEY_SLOTS) : 1;
    localparam int MOD_BITS    = 8;
    localparam int MOD_W       = $clog2(MOD_BITS);
    localparam int LED_W       = 3;

    localparam logic [7:0] MOD_BASE     = 8'hE0;
    localparam logic [7:0] USAGE_NUM    = 8'h53;
    localparam logic [7:0] USAGE_CAPS   = 8'h39;
    localparam logic [7:0] USAGE_SCROLL = 8'h47;
    localparam logic [7:0] USAGE_FIRST  = 8'h04;
    localparam logic [7:0] USAGE_LAST   = 8'h63;
    localparam logic [7:0] USAGE_HOLE_A = 8'h32;
    localparam logic [7:0] USAGE_HOLE_B = 8'h34;

    localparam logic [LED_W-1:0] LED_NUM    = 3'b001;
    localparam logic [LED_W-1:0] LED_CAPS   = 3'b010;
    localparam logic [LED_W-1:0] LED_SCROLL = 3'b100;

    typedef logic [7:0]             byte_t;
    typedef logic [USAGE_RANGE-1:0] map_t;

    typedef struct packed {
        logic  hit;     // slot holds a mapped usage
        logic  held;    // that usage was already held
        byte_t usage;
    } lane_res_t;

    function automatic logic usage_mapped(input byte_t u);
        logic ok;
        ok = ({1'b0, u} < 9'(USAGE_RANGE)) && (u >= USAGE_FIRST) && (u <= USAGE_LAST)
             && (u != USAGE_HOLE_A) && (u != USAGE_HOLE_B);
        return ok;
    endfunction

    function automatic logic [LED_W-1:0] led_toggle(input byte_t u);
        logic [LED_W-1:0] t;
        t = '0;
        if (u == USAGE_CAPS)
            t = LED_CAPS;
        else if (u == USAGE_NUM)
            t = LED_NUM;
        else if (u == USAGE_SCROLL)
            t = LED_SCROLL;
        return t;
    endfunction

    function automatic logic [USAGE_W-1:0] lowest_usage(input map_t v);
        logic [USAGE_W-1:0] idx;
        idx = '0;
        for (int i = USAGE_RANGE - 1; i >= 0; i--) begin
            if (v[i])
                idx = USAGE_W'(i);
        end
        return idx;
    endfunction

    function automatic logic [MOD_W-1:0] lowest_mod(input logic [MOD_BITS-1:0] v);
        logic [MOD_W-1:0] idx;
        idx = '0;
        for (int i = MOD_BITS - 1; i >= 0; i--) begin
            if (v[i])
                idx = MOD_W'(i);
        end
        return idx;
    endfunction

    function automatic logic [SLOT_W-1:0] lowest_slot(input logic [KEY_SLOTS-1:0] v);
        logic [SLOT_W-1:0] idx;
        idx = '0;
        for (int i = KEY_SLOTS - 1; i >= 0; i--) begin
            if (v[i])
                idx = SLOT_W'(i);
        end
        return idx;
    endfunction

endpackage

[rtl/hbk_slot_lane.sv]
// One key slot lane: checks the slot's usage against the map, decodes it
// to a one-hot usage map and looks up whether it is held. Uses hbk_pkg.
module hbk_slot_lane (
    input  hbk_pkg::byte_t    usage,
    input  hbk_pkg::map_t     held,
    output hbk_pkg::lane_res_t res,
    output hbk_pkg::map_t     onehot
);
    import hbk_pkg::*;

    logic hit;

    always_comb
    begin
        hit = usage_mapped(usage);
        for (int k = 0; k < USAGE_RANGE; k++) begin
            onehot[k] = hit && (usage == 8'(k));
        end
        res.hit   = hit;
        res.held  = |(held & onehot);
        res.usage = usage;
    end

endmodule

[rtl/hbk_merge.sv]
// Merges the slot lanes: the set of keys in the report, and which slots
// raise a press (not held, not a repeat of an earlier slot). Uses hbk_pkg.
module hbk_merge (
    input  hbk_pkg::lane_res_t lanes [hbk_pkg::KEY_SLOTS],
    input  hbk_pkg::map_t      lane_maps [hbk_pkg::KEY_SLOTS],
    output hbk_pkg::map_t      present,
    output logic [hbk_pkg::KEY_SLOTS-1:0] press
);
    import hbk_pkg::*;

    logic dup;

    always_comb
    begin
        present = '0;
        for (int i = 0; i < KEY_SLOTS; i++) begin
            present = present | lane_maps[i];
        end
        for (int i = 0; i < KEY_SLOTS; i++) begin
            dup = 1'b0;
            for (int j = 0; j < i; j++) begin
                if (lanes[j].hit && (lanes[j].usage == lanes[i].usage))
                    dup = 1'b1;
            end
            press[i] = lanes[i].hit && !lanes[i].held && !dup;
        end
    end

endmodule

[rtl/hid_boot_keyboard_report_to_events.sv]
// Top level of the boot keyboard report parser: slot lanes, merge and the
// event sequencer. Uses hbk_pkg, hbk_slot_lane and hbk_merge.
//
// Usage:
//   A report (modifier_bits, key_usage_0..5) is taken on in_valid & in_ready.
//   It yields up to 20 events on the out channel, one request per cycle unless stalled:
//   modifier changes (bit 0 first), releases of held keys that vanished
//   (ascending usage), then presses in slot order. last_event marks the
//   final event of a report; a report that changes nothing yields none.
//   The report is registered into the pending sets, and each event is then
//   registered from them onto the out channel. in_ready stays low until the
//   last event of a report has been generated.
//   The sequencer holds while out_valid is high and out_ready is low, so a
//   stalled receiver simply stretches the report; nothing is dropped.
//   The next report may be taken while the final event is still waiting.
//   Reset clears held modifiers, the held-key bitmap and the lock LED state.
module hid_boot_keyboard_report_to_events (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic [7:0]                    modifier_bits,
    input  logic [7:0]                    key_usage_0,
    input  logic [7:0]                    key_usage_1,
    input  logic [7:0]                    key_usage_2,
    input  logic [7:0]                    key_usage_3,
    input  logic [7:0]                    key_usage_4,
    input  logic [7:0]                    key_usage_5,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic [7:0]                    event_usage,
    output logic                          event_down,
    output logic [hbk_pkg::LED_W-1:0]     lock_leds,
    output logic                          leds_changed,
    output logic                          last_event
);
    import hbk_pkg::*;

    byte_t     slot_all [REPORT_KEYS];
    lane_res_t lanes [KEY_SLOTS];
    map_t      lane_maps [KEY_SLOTS];
    map_t      present;
    logic [KEY_SLOTS-1:0] press;

    // control state
    logic [MOD_BITS-1:0]  mod_pend_reg, mod_pend_next;
    map_t                 rel_pend_reg, rel_pend_next;
    logic [KEY_SLOTS-1:0] press_pend_reg, press_pend_next;
    map_t                 held_reg;
    logic [MOD_BITS-1:0]  hmod_reg;
    logic [LED_W-1:0]     led_reg, led_next;
    logic                 out_valid_reg;

    // payload
    byte_t            slot_reg [KEY_SLOTS];
    byte_t            usage_reg, usage_next;
    logic             down_reg, down_next;
    logic [LED_W-1:0] leds_out_reg;
    logic             changed_reg, changed_next;
    logic             last_reg, last_next;

    logic busy, accept, advance;
    logic [MOD_W-1:0]   mod_idx;
    logic [USAGE_W-1:0] rel_idx;
    logic [SLOT_W-1:0]  press_idx;
    logic [LED_W-1:0]   toggle;

    assign slot_all[0] = key_usage_0;
    assign slot_all[1] = key_usage_1;
    assign slot_all[2] = key_usage_2;
    assign slot_all[3] = key_usage_3;
    assign slot_all[4] = key_usage_4;
    assign slot_all[5] = key_usage_5;

    for (genvar g = 0; g < KEY_SLOTS; g++) begin : g_lane
        hbk_slot_lane u_lane (
            .usage  (slot_all[g]),
            .held   (held_reg),
            .res    (lanes[g]),
            .onehot (lane_maps[g])
        );
    end

    hbk_merge u_merge (
        .lanes     (lanes),
        .lane_maps (lane_maps),
        .present   (present),
        .press     (press)
    );

    assign busy     = (|mod_pend_reg) || (|rel_pend_reg) || (|press_pend_reg);
    assign in_ready = !busy;
    assign accept   = in_valid && in_ready;
    assign advance  = busy && (!out_valid_reg || out_ready);

    always_comb
    begin
        mod_idx         = lowest_mod(mod_pend_reg);
        rel_idx         = lowest_usage(rel_pend_reg);
        press_idx       = lowest_slot(press_pend_reg);
        mod_pend_next   = mod_pend_reg;
        rel_pend_next   = rel_pend_reg;
        press_pend_next = press_pend_reg;
        led_next        = led_reg;
        toggle          = '0;
        usage_next      = usage_reg;
        down_next       = down_reg;
        changed_next    = 1'b0;
        // phases drain in order: modifiers, releases, presses
        if (|mod_pend_reg) begin
            mod_pend_next[mod_idx] = 1'b0;
            usage_next = MOD_BASE | 8'(mod_idx);
            down_next  = hmod_reg[mod_idx];
        end else if (|rel_pend_reg) begin
            rel_pend_next[rel_idx] = 1'b0;
            usage_next = 8'(rel_idx);
            down_next  = 1'b0;
        end else begin
            press_pend_next[press_idx] = 1'b0;
            usage_next   = slot_reg[press_idx];
            down_next    = 1'b1;
            toggle       = led_toggle(slot_reg[press_idx]);
            led_next     = led_reg ^ toggle;
            changed_next = |toggle;
        end
        last_next = !((|mod_pend_next) || (|rel_pend_next) || (|press_pend_next));
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            mod_pend_reg   <= '0;
            rel_pend_reg   <= '0;
            press_pend_reg <= '0;
            held_reg       <= '0;
            hmod_reg       <= '0;
            led_reg        <= '0;
            out_valid_reg  <= 1'b0;
        end else begin
            if (accept) begin
                mod_pend_reg   <= modifier_bits ^ hmod_reg;
                rel_pend_reg   <= held_reg & ~present;
                press_pend_reg <= press;
                // after a report exactly its mapped keys are held
                held_reg       <= present;
                hmod_reg       <= modifier_bits;
            end else if (advance) begin
                mod_pend_reg   <= mod_pend_next;
                rel_pend_reg   <= rel_pend_next;
                press_pend_reg <= press_pend_next;
                led_reg        <= led_next;
            end
            if (advance)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept) begin
            for (int i = 0; i < KEY_SLOTS; i++) begin
                slot_reg[i] <= slot_all[i];
            end
        end
        if (advance) begin
            usage_reg    <= usage_next;
            down_reg     <= down_next;
            leds_out_reg <= led_next;
            changed_reg  <= changed_next;
            last_reg     <= last_next;
        end
    end

    assign out_valid    = out_valid_reg;
    assign event_usage  = usage_reg;
    assign event_down   = down_reg;
    assign lock_leds    = leds_out_reg;
    assign leds_changed = changed_reg;
    assign last_event   = last_reg;

endmodule

[dv/hbk_event_checker.sv]
`timescale 1ns / 100ps
// Checker for the boot keyboard report parser: watches both request channels,
// works out the key events each report should cause and compares them in order.
// Depends on hbk_pkg for widths and the lock-key usages.
module hbk_event_checker (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      in_valid,
    input  logic                      in_ready,
    input  logic [7:0]                modifier_bits,
    input  logic [7:0]                key_usage_0,
    input  logic [7:0]                key_usage_1,
    input  logic [7:0]                key_usage_2,
    input  logic [7:0]                key_usage_3,
    input  logic [7:0]                key_usage_4,
    input  logic [7:0]                key_usage_5,
    input  logic                      out_valid,
    input  logic                      out_ready,
    input  logic [7:0]                event_usage,
    input  logic                      event_down,
    input  logic [hbk_pkg::LED_W-1:0] lock_leds,
    input  logic                      leds_changed,
    input  logic                      last_event,
    output int                        errors,
    output int                        pending
);
    import hbk_pkg::*;

    typedef struct packed {
        logic [7:0]       usage;
        logic             down;
        logic [LED_W-1:0] leds;
        logic             changed;
        logic             last;
    } key_event_t;

    key_event_t                    expected_events [$];
    key_event_t                    want;
    logic [7:0]                    mods_held;
    logic [USAGE_RANGE-1:0]        keys_held;
    logic [LED_W-1:0]              leds_now;
    int                            fail_cnt = 0;

    assign errors = fail_cnt;

    function automatic logic is_key(input logic [7:0] u);
        return (int'(u) < USAGE_RANGE) && (u >= USAGE_FIRST) && (u <= USAGE_LAST)
               && (u != USAGE_HOLE_A) && (u != USAGE_HOLE_B);
    endfunction

    function automatic key_event_t make_event(input logic [7:0] usage, input logic down,
                                              input logic [LED_W-1:0] leds,
                                              input logic changed);
        key_event_t e;
        e.usage   = usage;
        e.down    = down;
        e.leds    = leds;
        e.changed = changed;
        e.last    = 1'b0;
        return e;
    endfunction

    // Modifier edges, then vanished keys by usage, then new presses by slot.
    task automatic derive_key_events(input logic [7:0] mods,
                                     input logic [REPORT_KEYS-1:0][7:0] slots);
        key_event_t       batch [$];
        key_event_t       e;
        logic [LED_W-1:0] flip;
        logic             seen;
        for (int b = 0; b < 8; b++) begin
            if (mods[b] != mods_held[b])
                batch.push_back(make_event(MOD_BASE + 8'(b), mods[b], leds_now, 1'b0));
        end
        mods_held = mods;
        for (int u = 0; u < USAGE_RANGE; u++) begin
            if (keys_held[u]) begin
                seen = 1'b0;
                for (int i = 0; i < KEY_SLOTS; i++) begin
                    if (is_key(slots[i]) && int'(slots[i]) == u)
                        seen = 1'b1;
                end
                if (!seen) begin
                    keys_held[u] = 1'b0;
                    batch.push_back(make_event(8'(u), 1'b0, leds_now, 1'b0));
                end
            end
        end
        for (int i = 0; i < KEY_SLOTS; i++) begin
            // a repeated usage in a later slot is already held by now
            if (is_key(slots[i]) && !keys_held[slots[i][USAGE_W-1:0]]) begin
                keys_held[slots[i][USAGE_W-1:0]] = 1'b1;
                flip = '0;
                if (slots[i] == USAGE_CAPS)
                    flip = LED_CAPS;
                else if (slots[i] == USAGE_NUM)
                    flip = LED_NUM;
                else if (slots[i] == USAGE_SCROLL)
                    flip = LED_SCROLL;
                leds_now = leds_now ^ flip;
                batch.push_back(make_event(slots[i], 1'b1, leds_now, flip != '0));
            end
        end
        if (batch.size() > 0) begin
            e = batch.pop_back();
            e.last = 1'b1;
            batch.push_back(e);
        end
        foreach (batch[k])
            expected_events.push_back(batch[k]);
    endtask

    // Events leaving at an edge belong to earlier reports, so compare before predicting.
    always @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            mods_held = '0;
            keys_held = '0;
            leds_now  = '0;
            expected_events.delete();
            pending <= 0;
        end
        else begin
            if (out_valid && out_ready) begin
                if (expected_events.size() == 0) begin
                    $error("event_usage: expected no event, got %0h", event_usage);
                    fail_cnt++;
                end
                else begin
                    want = expected_events.pop_front();
                    if (event_usage !== want.usage) begin
                        $error("event_usage: expected %0h, got %0h", want.usage, event_usage);
                        fail_cnt++;
                    end
                    if (event_down !== want.down) begin
                        $error("event_down: expected %0b, got %0b", want.down, event_down);
                        fail_cnt++;
                    end
                    if (lock_leds !== want.leds) begin
                        $error("lock_leds: expected %0b, got %0b", want.leds, lock_leds);
                        fail_cnt++;
                    end
                    if (leds_changed !== want.changed) begin
                        $error("leds_changed: expected %0b, got %0b", want.changed,
                               leds_changed);
                        fail_cnt++;
                    end
                    if (last_event !== want.last) begin
                        $error("last_event: expected %0b, got %0b", want.last, last_event);
                        fail_cnt++;
                    end
                end
            end
            if (in_valid && in_ready)
                derive_key_events(modifier_bits, {key_usage_5, key_usage_4, key_usage_3,
                                                  key_usage_2, key_usage_1, key_usage_0});
            pending <= expected_events.size();
        end
    end

endmodule

[dv/tb_hid_boot_keyboard_report_to_events.sv]
`timescale 1ns / 100ps
// Testbench top for the boot keyboard report parser: drives reports with random gaps and
// receiver stalls and gives the verdict. Depends on hbk_pkg, hbk_event_checker and the DUT.
module tb_hid_boot_keyboard_report_to_events;
    import hbk_pkg::*;

    localparam int CYCLE_LIMIT = 400000;

    typedef logic [REPORT_KEYS-1:0][7:0] slots_t;

    logic             clk           = 1'b0;
    logic             rst_n         = 1'b0;
    logic             in_valid      = 1'b0;
    logic             out_ready     = 1'b0;
    logic [7:0]       modifier_bits = '0;
    logic [7:0]       key_usage_0   = '0;
    logic [7:0]       key_usage_1   = '0;
    logic [7:0]       key_usage_2   = '0;
    logic [7:0]       key_usage_3   = '0;
    logic [7:0]       key_usage_4   = '0;
    logic [7:0]       key_usage_5   = '0;
    logic             in_ready;
    logic             out_valid;
    logic [7:0]       event_usage;
    logic             event_down;
    logic [LED_W-1:0] lock_leds;
    logic             leds_changed;
    logic             last_event;

    int     fail_total;
    int     waiting;
    int     cycles    = 0;
    int     gap_max   = 8;
    int     stall_max = 8;
    logic [7:0] roll_mods = '0;
    slots_t     roll_keys = '0;

    hid_boot_keyboard_report_to_events DUT (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .modifier_bits (modifier_bits),
        .key_usage_0   (key_usage_0),
        .key_usage_1   (key_usage_1),
        .key_usage_2   (key_usage_2),
        .key_usage_3   (key_usage_3),
        .key_usage_4   (key_usage_4),
        .key_usage_5   (key_usage_5),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .event_usage   (event_usage),
        .event_down    (event_down),
        .lock_leds     (lock_leds),
        .leds_changed  (leds_changed),
        .last_event    (last_event)
    );

    hbk_event_checker u_checker (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .modifier_bits (modifier_bits),
        .key_usage_0   (key_usage_0),
        .key_usage_1   (key_usage_1),
        .key_usage_2   (key_usage_2),
        .key_usage_3   (key_usage_3),
        .key_usage_4   (key_usage_4),
        .key_usage_5   (key_usage_5),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .event_usage   (event_usage),
        .event_down    (event_down),
        .lock_leds     (lock_leds),
        .leds_changed  (leds_changed),
        .last_event    (last_event),
        .errors        (fail_total),
        .pending       (waiting)
    );

    initial begin
        forever #4 clk = ~clk;
    end

    always @(posedge clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("tb: failure");
            $finish;
        end
    end

    // Receiver: a fresh stall before every event.
    initial begin
        int stall;
        @(posedge rst_n);
        forever begin
            stall = $urandom_range(0, stall_max);
            if (stall > 0) begin
                out_ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            out_ready <= 1'b1;
            do @(posedge clk); while (!out_valid);
        end
    end

    task automatic send_report(input logic [7:0] mods, input slots_t keys);
        int gap;
        gap = $urandom_range(0, gap_max);
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid      <= 1'b1;
        modifier_bits <= mods;
        key_usage_0   <= keys[0];
        key_usage_1   <= keys[1];
        key_usage_2   <= keys[2];
        key_usage_3   <= keys[3];
        key_usage_4   <= keys[4];
        key_usage_5   <= keys[5];
        do @(posedge clk); while (!in_ready);
    endtask

    // Hold off the sender until every outstanding event has been taken.
    task automatic drain_events();
        in_valid <= 1'b0;
        @(posedge clk);
        while (waiting != 0) @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    // Lock keys and range ends come up often enough to exercise the LEDs.
    function automatic logic [7:0] pick_key();
        case ($urandom_range(0, 9))
            0:       return USAGE_CAPS;
            1:       return USAGE_NUM;
            2:       return USAGE_SCROLL;
            3:       return ($urandom_range(0, 1) != 0) ? USAGE_FIRST : USAGE_LAST;
            default: return 8'($urandom_range(int'(USAGE_FIRST), int'(USAGE_LAST)));
        endcase
    endfunction

    task automatic next_report();
        int     r;
        slots_t odd_keys;
        r = $urandom_range(0, 99);
        if (r < 70) begin
            // typing: one or two random edits (set, clear or shift in a key, or flip a modifier) per report
            repeat ($urandom_range(1, 2)) begin
                case ($urandom_range(0, 3))
                    0:       roll_keys[$urandom_range(0, 5)] = pick_key();
                    1:       roll_keys[$urandom_range(0, 5)] = 8'h00;
                    2:       roll_mods[$urandom_range(0, 7)] ^= 1'b1;
                    default: roll_keys = {roll_keys[REPORT_KEYS-2:0], pick_key()};
                endcase
            end
            send_report(roll_mods, roll_keys);
        end
        else if (r < 85) begin
            for (int i = 0; i < REPORT_KEYS; i++)
                odd_keys[i] = 8'($urandom);
            send_report(8'($urandom), odd_keys);
        end
        else begin
            odd_keys = roll_keys;
            case ($urandom_range(0, 2))
                0:       odd_keys = {REPORT_KEYS{8'h01}};
                1:       odd_keys[$urandom_range(0, 5)] = odd_keys[$urandom_range(0, 5)];
                default: odd_keys[$urandom_range(0, 5)] = MOD_BASE + 8'($urandom_range(0, 7));
            endcase
            send_report(roll_mods, odd_keys);
        end
    endtask

    initial begin
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_report(8'h00, {8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00});
        send_report(8'hFF, {8'h09, 8'h08, 8'h07, 8'h06, 8'h05, 8'h04});
        // every modifier flips, six releases and six presses: the longest report
        send_report(8'h00, {8'h12, 8'h11, 8'h10, 8'h47, 8'h53, 8'h39});
        send_report(8'h00, {8'h12, 8'h11, 8'h10, 8'h47, 8'h53, 8'h39});
        send_report(8'h00, {8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h39});
        drain_events();
        send_report(8'h00, {8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00});
        send_report(8'h00, {8'h15, 8'h15, 8'h39, 8'h00, 8'h39, 8'h00});
        send_report(8'h00, {8'h01, 8'h01, 8'h01, 8'h01, 8'h01, 8'h01});
        send_report(8'h00, {8'hE7, 8'hE0, 8'h34, 8'h32, 8'h03, 8'h02});
        send_report(8'h00, {8'hFF, 8'h80, 8'h7F, 8'h65, 8'h64, 8'h00});
        send_report(8'h55, {8'h00, 8'h00, 8'h00, 8'h00, 8'h63, 8'h04});
        send_report(8'hAA, {8'h00, 8'h00, 8'h00, 8'h00, 8'h04, 8'h63});
        send_report(8'h00, {8'h47, 8'h53, 8'h39, 8'h63, 8'h04, 8'h05});
        send_report(8'h81, {8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00});
        send_report(8'h00, {8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00});
        drain_events();

        // phases cover gaps and stalls on both sides, and neither
        for (int ph = 0; ph < 4; ph++) begin
            gap_max   = (ph % 2 == 0) ? 8 : 0;
            stall_max = (ph < 2) ? 8 : 0;
            repeat (50) next_report();
            drain_events();
        end

        repeat (30) @(posedge clk);
        if (fail_total == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
